// ----- rtl/kops_pkg.sv -----
// Shared constants, command and status types, and Horner tables of the orbit solver.
package kops_pkg;

    localparam int NUM_BODIES     = 8;
    localparam int MAX_ITERATIONS = 100;
    localparam int ITER_W         = $clog2(MAX_ITERATIONS + 1);
    localparam int REM_W          = $clog2(NUM_BODIES + 1);
    localparam int DIV_STEPS      = 34;
    localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

    // Body phase offset floor(i * 2^32 / NUM_BODIES) is built up as whole part plus remainder.
    localparam logic [31:0]      OFF_STEP  = 32'((64'd1 << 32) / NUM_BODIES);
    localparam logic [REM_W-1:0] OFF_FRAC  = REM_W'((64'd1 << 32) % NUM_BODIES);
    localparam logic [REM_W:0]   OFF_DIV   = (REM_W + 1)'(NUM_BODIES);
    localparam logic [5:0]       LAST_BODY = 6'(NUM_BODIES - 1);
    localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(MAX_ITERATIONS - 1);

    localparam logic signed [33:0] TWO_PI_Q28     = 34'sd1686629713;
    localparam logic signed [33:0] TWO_PI_Q30     = 34'sd6746518852;
    localparam logic signed [33:0] INV_TWO_PI_Q32 = 34'sd683565276;
    localparam logic signed [31:0] PI_Q28         = 32'sd843314857;
    localparam logic signed [31:0] ONE_Q28        = 32'sd268435456;
    localparam logic [30:0]        ONE_Q30        = 31'h4000_0000;
    localparam logic [15:0]        ECC_HIGH_START = 16'd52428;

    // Configuration register indexes.
    localparam logic [1:0] REG_SEMI_MAJOR   = 2'd0;
    localparam logic [1:0] REG_SEMI_MINOR   = 2'd1;
    localparam logic [1:0] REG_ECCENTRICITY = 2'd2;
    localparam logic [1:0] REG_PHASE_RATE   = 2'd3;

    // Datapath operations.
    localparam logic [4:0] OP_NOP   = 5'd0;
    localparam logic [4:0] OP_LOAD  = 5'd1;
    localparam logic [4:0] OP_ACC   = 5'd2;
    localparam logic [4:0] OP_MEAN  = 5'd3;
    localparam logic [4:0] OP_ANG   = 5'd4;
    localparam logic [4:0] OP_X     = 5'd5;
    localparam logic [4:0] OP_X2    = 5'd6;
    localparam logic [4:0] OP_DIVA  = 5'd7;
    localparam logic [4:0] OP_DIVB  = 5'd8;
    localparam logic [4:0] OP_HMUL  = 5'd9;
    localparam logic [4:0] OP_SFIN  = 5'd10;
    localparam logic [4:0] OP_MAP   = 5'd11;
    localparam logic [4:0] OP_NF    = 5'd12;
    localparam logic [4:0] OP_NG    = 5'd13;
    localparam logic [4:0] OP_DINIT = 5'd14;
    localparam logic [4:0] OP_DSTEP = 5'd15;
    localparam logic [4:0] OP_NUPD  = 5'd16;
    localparam logic [4:0] OP_PX    = 5'd17;
    localparam logic [4:0] OP_PZ    = 5'd18;
    localparam logic [4:0] OP_EMIT  = 5'd19;

    // Horner term indexes: sine terms first, then cosine terms.
    localparam logic [3:0] H_SIN_FIRST = 4'd0;
    localparam logic [3:0] H_SIN_LAST  = 4'd4;
    localparam logic [3:0] H_COS_FIRST = 4'd5;
    localparam logic [3:0] H_COS_LAST  = 4'd10;

    typedef struct packed {
        logic [4:0] op;
        logic [3:0] hidx;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
        logic last_body;
        logic small_step;
    } dp_status_t;

    function automatic logic [7:0] horner_div(input logic [3:0] idx);
        logic [7:0] d;
        unique case (idx)
            4'd0:    d = 8'd110;
            4'd1:    d = 8'd72;
            4'd2:    d = 8'd42;
            4'd3:    d = 8'd20;
            4'd4:    d = 8'd6;
            4'd5:    d = 8'd132;
            4'd6:    d = 8'd90;
            4'd7:    d = 8'd56;
            4'd8:    d = 8'd30;
            4'd9:    d = 8'd12;
            default: d = 8'd2;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor); the product estimate is at most one below the true quotient.
    function automatic logic [31:0] horner_recip(input logic [3:0] idx);
        logic [31:0] r;
        unique case (idx)
            4'd0:    r = 32'd39045157;
            4'd1:    r = 32'd59652323;
            4'd2:    r = 32'd102261126;
            4'd3:    r = 32'd214748364;
            4'd4:    r = 32'd715827882;
            4'd5:    r = 32'd32537631;
            4'd6:    r = 32'd47721858;
            4'd7:    r = 32'd76695844;
            4'd8:    r = 32'd143165576;
            4'd9:    r = 32'd357913941;
            default: r = 32'd2147483648;
        endcase
        return r;
    endfunction

endpackage

// ----- rtl/kops_ctrl.sv -----
// Sequencer that steps the datapath through phase update, Newton solve and output per body.
module kops_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  kops_pkg::dp_status_t  status,
    output kops_pkg::dp_cmd_t     cmd
);

    localparam logic [4:0] S_IDLE  = 5'd0;
    localparam logic [4:0] S_ACC   = 5'd1;
    localparam logic [4:0] S_MEAN  = 5'd2;
    localparam logic [4:0] S_ANG   = 5'd3;
    localparam logic [4:0] S_X     = 5'd4;
    localparam logic [4:0] S_X2    = 5'd5;
    localparam logic [4:0] S_DIVA  = 5'd6;
    localparam logic [4:0] S_DIVB  = 5'd7;
    localparam logic [4:0] S_HMUL  = 5'd8;
    localparam logic [4:0] S_SFIN  = 5'd9;
    localparam logic [4:0] S_MAP   = 5'd10;
    localparam logic [4:0] S_NF    = 5'd11;
    localparam logic [4:0] S_NG    = 5'd12;
    localparam logic [4:0] S_DINIT = 5'd13;
    localparam logic [4:0] S_DSTEP = 5'd14;
    localparam logic [4:0] S_NUPD  = 5'd15;
    localparam logic [4:0] S_CHK   = 5'd16;
    localparam logic [4:0] S_PX    = 5'd17;
    localparam logic [4:0] S_PZ    = 5'd18;
    localparam logic [4:0] S_EMIT  = 5'd19;

    logic [4:0]                     state_reg, state_next;
    logic [3:0]                     h_reg, h_next;
    logic [kops_pkg::DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [kops_pkg::ITER_W-1:0]    it_reg, it_next;
    logic                           final_reg, final_next;

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        h_next     = h_reg;
        cnt_next   = cnt_reg;
        it_next    = it_reg;
        final_next = final_reg;
        cmd.op     = kops_pkg::OP_NOP;
        cmd.hidx   = h_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.op     = kops_pkg::OP_LOAD;
                    state_next = S_ACC;
                end
            end
            S_ACC: begin
                cmd.op     = kops_pkg::OP_ACC;
                state_next = S_MEAN;
            end
            S_MEAN: begin
                cmd.op     = kops_pkg::OP_MEAN;
                it_next    = '0;
                final_next = 1'b0;
                state_next = S_ANG;
            end
            S_ANG: begin
                cmd.op     = kops_pkg::OP_ANG;
                state_next = S_X;
            end
            S_X: begin
                cmd.op     = kops_pkg::OP_X;
                state_next = S_X2;
            end
            S_X2: begin
                cmd.op     = kops_pkg::OP_X2;
                h_next     = kops_pkg::H_SIN_FIRST;
                state_next = S_DIVA;
            end
            S_DIVA: begin
                cmd.op     = kops_pkg::OP_DIVA;
                state_next = S_DIVB;
            end
            S_DIVB: begin
                cmd.op = kops_pkg::OP_DIVB;
                priority if (h_reg == kops_pkg::H_SIN_LAST) begin
                    state_next = S_SFIN;
                end else if (h_reg == kops_pkg::H_COS_LAST) begin
                    state_next = S_MAP;
                end else begin
                    h_next     = h_reg + 4'd1;
                    state_next = S_HMUL;
                end
            end
            S_HMUL: begin
                cmd.op     = kops_pkg::OP_HMUL;
                state_next = S_DIVA;
            end
            S_SFIN: begin
                cmd.op     = kops_pkg::OP_SFIN;
                h_next     = kops_pkg::H_COS_FIRST;
                state_next = S_DIVA;
            end
            S_MAP: begin
                cmd.op     = kops_pkg::OP_MAP;
                state_next = final_reg ? S_PX : S_NF;
            end
            S_NF: begin
                cmd.op     = kops_pkg::OP_NF;
                state_next = S_NG;
            end
            S_NG: begin
                cmd.op     = kops_pkg::OP_NG;
                state_next = S_DINIT;
            end
            S_DINIT: begin
                cmd.op     = kops_pkg::OP_DINIT;
                cnt_next   = '0;
                state_next = S_DSTEP;
            end
            S_DSTEP: begin
                cmd.op   = kops_pkg::OP_DSTEP;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == kops_pkg::DIV_CNT_W'(kops_pkg::DIV_STEPS - 1)) begin
                    state_next = S_NUPD;
                end
            end
            S_NUPD: begin
                cmd.op     = kops_pkg::OP_NUPD;
                state_next = S_CHK;
            end
            S_CHK: begin
                // The converged or last iterate gets one more sine and cosine for the output.
                if (status.small_step || it_reg == kops_pkg::LAST_ITER) begin
                    final_next = 1'b1;
                end else begin
                    it_next = it_reg + 1'b1;
                end
                state_next = S_ANG;
            end
            S_PX: begin
                cmd.op     = kops_pkg::OP_PX;
                state_next = S_PZ;
            end
            S_PZ: begin
                cmd.op     = kops_pkg::OP_PZ;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (status.out_free) begin
                    cmd.op     = kops_pkg::OP_EMIT;
                    state_next = status.last_body ? S_IDLE : S_MEAN;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            h_reg     <= '0;
            cnt_reg   <= '0;
            it_reg    <= '0;
            final_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            h_reg     <= h_next;
            cnt_reg   <= cnt_next;
            it_reg    <= it_next;
            final_reg <= final_next;
        end
    end

endmodule

// ----- rtl/kops_dp.sv -----
// Datapath: configuration, phase accumulator, shared multiplier, sine/cosine, Newton divider.
module kops_dp (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [1:0]           cfg_index,
    input  logic [31:0]          cfg_data,
    input  logic [15:0]          s_delta_ticks,
    input  kops_pkg::dp_cmd_t    cmd,
    output kops_pkg::dp_status_t status,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic [5:0]           m_body_index,
    output logic signed [17:0]   m_pos_x,
    output logic signed [16:0]   m_pos_z,
    output logic                 m_last
);

    logic [15:0] semi_major_reg, semi_major_next;
    logic [15:0] semi_minor_reg, semi_minor_next;
    logic [15:0] ecc_reg, ecc_next;
    logic [31:0] phase_rate_reg, phase_rate_next;
    logic [31:0] acc_reg, acc_next;
    logic        out_valid_reg, out_valid_next;

    logic [15:0]                dt_reg, dt_next;
    logic [31:0]                off_reg, off_next;
    logic [kops_pkg::REM_W-1:0] frac_reg, frac_next;
    logic [5:0]                 body_reg, body_next;
    logic [30:0]                m_reg, m_next;
    logic signed [31:0]         e_reg, e_next;
    logic [1:0]                 quad_reg, quad_next;
    logic                       swap_reg, swap_next;
    logic [29:0]                rf_reg, rf_next;
    logic [29:0]                x_reg, x_next;
    logic [29:0]                x2_reg, x2_next;
    logic [29:0]                v_reg, v_next;
    logic [29:0]                q_reg, q_next;
    logic [30:0]                hp_reg, hp_next;
    logic [29:0]                sraw_reg, sraw_next;
    logic signed [31:0]         sn_reg, sn_next;
    logic signed [31:0]         cs_reg, cs_next;
    logic signed [33:0]         f_reg, f_next;
    logic [29:0]                g_reg, g_next;
    logic                       fneg_reg, fneg_next;
    logic                       ovf_reg, ovf_next;
    logic [29:0]                rem_reg, rem_next;
    logic [33:0]                dq_reg, dq_next;
    logic [33:0]                quo_reg, quo_next;
    logic                       small_reg, small_next;
    logic [17:0]                px_reg, px_next;
    logic [16:0]                pz_reg, pz_next;
    logic [5:0]                 out_body_reg, out_body_next;
    logic [17:0]                out_x_reg, out_x_next;
    logic [16:0]                out_z_reg, out_z_next;
    logic                       out_last_reg, out_last_next;

    logic signed [33:0] mul_a, mul_b;
    logic signed [67:0] prod;
    logic signed [67:0] px_sum, pz_sum;
    logic [31:0]        ph;
    logic [31:0]        turn;
    logic [29:0]        turn_rest;
    logic [7:0]         hdiv;
    logic [37:0]        qd;
    logic [37:0]        qrem;
    logic [29:0]        qfix;
    logic [30:0]        s0, c0;
    logic signed [31:0] sp, cp;
    logic signed [31:0] ps18;
    logic [33:0]        af;
    logic [30:0]        trial;
    logic               trial_ge;
    logic [34:0]        step_mag;
    logic signed [35:0] step_s;
    logic signed [36:0] nx_w;
    logic signed [31:0] nx_c;
    logic signed [32:0] nx_d;
    logic [kops_pkg::REM_W:0] frac_sum;

    assign ph        = acc_reg + off_reg;
    assign turn      = prod[59:28];
    assign turn_rest = turn[29:0];
    assign hdiv      = kops_pkg::horner_div(cmd.hidx);
    assign qd        = 38'(q_reg) * 38'(hdiv);
    assign qrem      = 38'(v_reg) - qd;
    assign qfix      = q_reg + 30'(qrem >= 38'(hdiv));
    assign s0        = swap_reg ? hp_reg : {1'b0, sraw_reg};
    assign c0        = swap_reg ? {1'b0, sraw_reg} : hp_reg;
    assign sp        = $signed({1'b0, s0});
    assign cp        = $signed({1'b0, c0});
    assign ps18      = prod[49:18];
    assign af        = f_reg[33] ? 34'(-f_reg) : 34'(f_reg);
    assign trial     = {rem_reg, dq_reg[33]};
    assign trial_ge  = trial >= {1'b0, g_reg};
    // An overflowed quotient only needs to be large enough to saturate the iterate.
    assign step_mag  = ovf_reg ? 35'h4_0000_0000 : {1'b0, quo_reg};
    assign step_s    = fneg_reg ? -$signed({1'b0, step_mag}) : $signed({1'b0, step_mag});
    assign nx_w      = 37'(e_reg) - 37'(step_s);
    assign nx_d      = 33'(nx_c) - 33'(e_reg);
    assign px_sum    = prod + 68'sd536870912;
    assign pz_sum    = 68'sd536870912 - prod;
    assign frac_sum  = {1'b0, frac_reg} + {1'b0, kops_pkg::OFF_FRAC};

    always_comb begin
        priority if (nx_w > 37'sd2147483647) begin
            nx_c = 32'sh7FFF_FFFF;
        end else if (nx_w < -37'sd2147483648) begin
            nx_c = 32'sh8000_0000;
        end else begin
            nx_c = nx_w[31:0];
        end
    end

    // One shared multiplier; the operation picks its operands.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (cmd.op)
            kops_pkg::OP_ACC: begin
                mul_a = $signed({18'b0, dt_reg});
                mul_b = $signed({2'b0, phase_rate_reg});
            end
            kops_pkg::OP_MEAN: begin
                mul_a = $signed({2'b0, ph});
                mul_b = kops_pkg::TWO_PI_Q28;
            end
            kops_pkg::OP_ANG: begin
                mul_a = 34'(e_reg);
                mul_b = kops_pkg::INV_TWO_PI_Q32;
            end
            kops_pkg::OP_X: begin
                mul_a = $signed({4'b0, rf_reg});
                mul_b = kops_pkg::TWO_PI_Q30;
            end
            kops_pkg::OP_X2: begin
                mul_a = $signed({4'b0, x_reg});
                mul_b = $signed({4'b0, x_reg});
            end
            kops_pkg::OP_DIVA: begin
                mul_a = $signed({4'b0, v_reg});
                mul_b = $signed({2'b0, kops_pkg::horner_recip(cmd.hidx)});
            end
            kops_pkg::OP_HMUL: begin
                mul_a = $signed({4'b0, x2_reg});
                mul_b = $signed({3'b0, hp_reg});
            end
            kops_pkg::OP_SFIN: begin
                mul_a = $signed({4'b0, x_reg});
                mul_b = $signed({3'b0, hp_reg});
            end
            kops_pkg::OP_NF: begin
                mul_a = $signed({18'b0, ecc_reg});
                mul_b = 34'(sn_reg);
            end
            kops_pkg::OP_NG: begin
                mul_a = $signed({18'b0, ecc_reg});
                mul_b = 34'(cs_reg);
            end
            kops_pkg::OP_PX: begin
                mul_a = $signed({18'b0, semi_major_reg});
                mul_b = 34'(cs_reg) - $signed({4'b0, ecc_reg, 14'b0});
            end
            kops_pkg::OP_PZ: begin
                mul_a = $signed({18'b0, semi_minor_reg});
                mul_b = 34'(sn_reg);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    always_comb begin
        semi_major_next = semi_major_reg;
        semi_minor_next = semi_minor_reg;
        ecc_next        = ecc_reg;
        phase_rate_next = phase_rate_reg;
        acc_next        = acc_reg;
        dt_next         = dt_reg;
        off_next        = off_reg;
        frac_next       = frac_reg;
        body_next       = body_reg;
        m_next          = m_reg;
        e_next          = e_reg;
        quad_next       = quad_reg;
        swap_next       = swap_reg;
        rf_next         = rf_reg;
        x_next          = x_reg;
        x2_next         = x2_reg;
        v_next          = v_reg;
        q_next          = q_reg;
        hp_next         = hp_reg;
        sraw_next       = sraw_reg;
        sn_next         = sn_reg;
        cs_next         = cs_reg;
        f_next          = f_reg;
        g_next          = g_reg;
        fneg_next       = fneg_reg;
        ovf_next        = ovf_reg;
        rem_next        = rem_reg;
        dq_next         = dq_reg;
        quo_next        = quo_reg;
        small_next      = small_reg;
        px_next         = px_reg;
        pz_next         = pz_reg;
        out_body_next   = out_body_reg;
        out_x_next      = out_x_reg;
        out_z_next      = out_z_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !m_ready;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                kops_pkg::REG_SEMI_MAJOR:   semi_major_next = cfg_data[15:0];
                kops_pkg::REG_SEMI_MINOR:   semi_minor_next = cfg_data[15:0];
                kops_pkg::REG_ECCENTRICITY: ecc_next        = cfg_data[15:0];
                kops_pkg::REG_PHASE_RATE:   phase_rate_next = cfg_data;
            endcase
        end

        unique case (cmd.op)
            kops_pkg::OP_LOAD: begin
                dt_next = s_delta_ticks;
            end
            kops_pkg::OP_ACC: begin
                acc_next  = acc_reg + prod[31:0];
                off_next  = '0;
                frac_next = '0;
                body_next = '0;
            end
            kops_pkg::OP_MEAN: begin
                m_next = prod[62:32];
                e_next = (ecc_reg > kops_pkg::ECC_HIGH_START) ? kops_pkg::PI_Q28
                                                              : $signed({1'b0, prod[62:32]});
            end
            kops_pkg::OP_ANG: begin
                // Fold the angle into the first half quadrant; sine and cosine swap above it.
                quad_next = turn[31:30];
                swap_next = turn_rest[29];
                rf_next   = turn_rest[29] ? 30'(kops_pkg::ONE_Q30 - {1'b0, turn_rest})
                                          : turn_rest;
            end
            kops_pkg::OP_X: begin
                x_next = prod[61:32];
            end
            kops_pkg::OP_X2: begin
                x2_next = prod[59:30];
                v_next  = prod[59:30];
            end
            kops_pkg::OP_DIVA: begin
                q_next = prod[61:32];
            end
            kops_pkg::OP_DIVB: begin
                hp_next = kops_pkg::ONE_Q30 - {1'b0, qfix};
            end
            kops_pkg::OP_HMUL: begin
                v_next = prod[59:30];
            end
            kops_pkg::OP_SFIN: begin
                sraw_next = prod[59:30];
                v_next    = x2_reg;
            end
            kops_pkg::OP_MAP: begin
                unique case (quad_reg)
                    2'd0: begin
                        sn_next = sp;
                        cs_next = cp;
                    end
                    2'd1: begin
                        sn_next = cp;
                        cs_next = -sp;
                    end
                    2'd2: begin
                        sn_next = -sp;
                        cs_next = -cp;
                    end
                    default: begin
                        sn_next = -cp;
                        cs_next = sp;
                    end
                endcase
            end
            kops_pkg::OP_NF: begin
                f_next = 34'(e_reg) - 34'(ps18) - $signed({3'b0, m_reg});
            end
            kops_pkg::OP_NG: begin
                g_next = 30'(kops_pkg::ONE_Q28 - ps18);
            end
            kops_pkg::OP_DINIT: begin
                // The top bits of |f| * 2^28 are checked first so the quotient fits 34 bits.
                fneg_next = f_reg[33];
                ovf_next  = {2'b0, af[33:6]} >= g_reg;
                rem_next  = {2'b0, af[33:6]};
                dq_next   = {af[5:0], 28'b0};
                quo_next  = '0;
            end
            kops_pkg::OP_DSTEP: begin
                rem_next = trial_ge ? 30'(trial - {1'b0, g_reg}) : trial[29:0];
                dq_next  = {dq_reg[32:0], 1'b0};
                quo_next = {quo_reg[32:0], trial_ge};
            end
            kops_pkg::OP_NUPD: begin
                e_next     = nx_c;
                small_next = (nx_d > -33'sd256) && (nx_d < 33'sd256);
            end
            kops_pkg::OP_PX: begin
                px_next = px_sum[47:30];
            end
            kops_pkg::OP_PZ: begin
                pz_next = pz_sum[46:30];
            end
            kops_pkg::OP_EMIT: begin
                out_valid_next = 1'b1;
                out_body_next  = body_reg;
                out_x_next     = px_reg;
                out_z_next     = pz_reg;
                out_last_next  = (body_reg == kops_pkg::LAST_BODY);
                body_next      = body_reg + 6'd1;
                if (frac_sum >= kops_pkg::OFF_DIV) begin
                    frac_next = kops_pkg::REM_W'(frac_sum - kops_pkg::OFF_DIV);
                    off_next  = off_reg + kops_pkg::OFF_STEP + 32'd1;
                end else begin
                    frac_next = frac_sum[kops_pkg::REM_W-1:0];
                    off_next  = off_reg + kops_pkg::OFF_STEP;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            semi_major_reg <= '0;
            semi_minor_reg <= '0;
            ecc_reg        <= '0;
            phase_rate_reg <= '0;
            acc_reg        <= '0;
            out_valid_reg  <= 1'b0;
        end else begin
            semi_major_reg <= semi_major_next;
            semi_minor_reg <= semi_minor_next;
            ecc_reg        <= ecc_next;
            phase_rate_reg <= phase_rate_next;
            acc_reg        <= acc_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        dt_reg       <= dt_next;
        off_reg      <= off_next;
        frac_reg     <= frac_next;
        body_reg     <= body_next;
        m_reg        <= m_next;
        e_reg        <= e_next;
        quad_reg     <= quad_next;
        swap_reg     <= swap_next;
        rf_reg       <= rf_next;
        x_reg        <= x_next;
        x2_reg       <= x2_next;
        v_reg        <= v_next;
        q_reg        <= q_next;
        hp_reg       <= hp_next;
        sraw_reg     <= sraw_next;
        sn_reg       <= sn_next;
        cs_reg       <= cs_next;
        f_reg        <= f_next;
        g_reg        <= g_next;
        fneg_reg     <= fneg_next;
        ovf_reg      <= ovf_next;
        rem_reg      <= rem_next;
        dq_reg       <= dq_next;
        quo_reg      <= quo_next;
        small_reg    <= small_next;
        px_reg       <= px_next;
        pz_reg       <= pz_next;
        out_body_reg <= out_body_next;
        out_x_reg    <= out_x_next;
        out_z_reg    <= out_z_next;
        out_last_reg <= out_last_next;
    end

    assign status.out_free   = !out_valid_reg || m_ready;
    assign status.last_body  = (body_reg == kops_pkg::LAST_BODY);
    assign status.small_step = small_reg;

    assign m_valid      = out_valid_reg;
    assign m_body_index = out_body_reg;
    assign m_pos_x      = $signed(out_x_reg);
    assign m_pos_z      = $signed(out_z_reg);
    assign m_last       = out_last_reg;

endmodule

// ----- rtl/kepler_orbit_position_solver.sv -----
// Top level of the Kepler orbit position solver: sequencer plus datapath.
//
// Each input item on s_ (valid/ready) carries a tick count that advances the
// mean-anomaly phase accumulator; the block then sends NUM_BODIES result items
// on m_ (valid/ready), one per body in index order, with m_last on the final one.
// Configuration registers are written through cfg_wr_en/cfg_index/cfg_data
// with no wait; write them only while the block is idle.
// One shared multiplier and a radix-2 divider do all the work in order. Each
// Newton iteration of a body computes a sine/cosine pair and runs the divider;
// the last iterate gets one more pair for the output. A body runs at most
// MAX_ITERATIONS Newton iterations. s_ready is high only between items, so a
// new item is not taken until every body of the last one has reached the
// output register.
// A finished result waits in an output register; while the receiver stalls,
// the next body's solve runs and then holds until that register frees.
// Synchronous active-low reset clears phase, configuration, output valid and any item in flight.
module kepler_orbit_position_solver (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_wr_en,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [15:0]        s_delta_ticks,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [5:0]         m_body_index,
    output logic signed [17:0] m_pos_x,
    output logic signed [16:0] m_pos_z,
    output logic               m_last
);

    kops_pkg::dp_cmd_t    cmd;
    kops_pkg::dp_status_t status;

    kops_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    kops_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_delta_ticks (s_delta_ticks),
        .cmd           (cmd),
        .status        (status),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_body_index  (m_body_index),
        .m_pos_x       (m_pos_x),
        .m_pos_z       (m_pos_z),
        .m_last        (m_last)
    );

endmodule
